FILE: sv/imucfd_pkg.sv
package imucfd_pkg;

    // Angle scaling of the yaw values (fraction bits of one degree).
    localparam int FRAC_BITS = 16;

    localparam int ID_W       = 11;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int QUAT_W     = 14;
    localparam int VAL_W      = 32;
    localparam int MAG_W      = VAL_W + 1;
    localparam int PROD_W     = 48;
    localparam int FOLD_W     = VAL_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int N_LANES    = 4;
    localparam int N_STAGES   = 6;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 176;

    // Divisors of the linear mapping: 2^bits - 1 for both raw widths.
    localparam logic [RAW_W-1:0] DEN_WIDE = {RAW_W{1'b1}};
    localparam logic [RAW_W-1:0] DEN_QUAT = RAW_W'((1 << QUAT_W) - 1);

    // Yaw unwrap arithmetic.
    localparam int DIFF_W     = 34;
    localparam int TURN_W     = 16;
    localparam int TOT_W      = DIFF_W + TURN_W + 1;
    localparam int TOT_OUT_W  = 48;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(64'd180 << FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(64'd360 << FRAC_BITS);
    localparam logic signed [TOT_W-1:0]  TOTAL_MAX =
        TOT_W'({1'b0, {(TOT_OUT_W - 1){1'b1}}});
    localparam logic signed [TOT_W-1:0]  TOTAL_MIN = ~TOTAL_MAX;
    localparam logic signed [TURN_W-1:0] TURN_MAX  = {1'b0, {(TURN_W - 1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN  = {1'b1, {(TURN_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_EULER = 2'd2,
        KIND_QUAT  = 2'd3
    } kind_t;

    // Frame type byte.
    localparam logic [BYTE_W-1:0] FT_ACCEL = 8'd1;
    localparam logic [BYTE_W-1:0] FT_GYRO  = 8'd2;
    localparam logic [BYTE_W-1:0] FT_EULER = 8'd3;
    localparam logic [BYTE_W-1:0] FT_QUAT  = 8'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT     = 3'd6;

    // A range is kept as its minimum and the sign and magnitude of max - min.
    typedef struct packed {
        logic signed [VAL_W-1:0] lo;
        logic [MAG_W-1:0]        mag;
        logic                    neg;
    } range_t;

    typedef struct packed {
        logic [ID_W-1:0] match_id;
        range_t          accel;
        range_t          gyro;
        range_t          pitch;
        range_t          yaw;
        range_t          roll;
        range_t          quat;
    } cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_en_t;

endpackage

FILE: sv/imu_can_frame_decoder.sv
// IMU CAN reply frame decoder.
// Received frames enter on the s_ channel: identifier and payload bytes in
// s_tdata, the type byte in s_tuser. Frames for another identifier or of an
// unknown type are taken and dropped. Each other frame gives one item on the
// m_ channel: four Q16.16 values and the unwrapped yaw in m_tdata, the kind in
// m_tuser. Ranges and the identifier are written on the cfg_ channel, which is
// always ready; write it only while no item is in flight.
// Each item passes through the input register, four scaling lanes, each a
// multiplier stage followed by three stages of constant division and range
// offset, and the output register where the yaw turn counter is updated.
// One item is accepted in every cycle while a stall on m_tready does not
// hold the pipeline.
// Each stage moves on whenever the stage after it is empty or moving, so a
// stall on m_tready fills the bubbles first and drops s_tready only once all
// six stages hold an item. The output item is held while m_tready is low.
// Reset empties the pipeline and clears the identifier, all ranges, the last
// yaw and the turn counter.
module imu_can_frame_decoder
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // frame_id, data_byte_1 .. data_byte_7, zero fill
    input  logic [imucfd_pkg::IN_DATA_W-1:0]        s_tdata,
    // data_byte_0
    input  logic [imucfd_pkg::BYTE_W-1:0]           s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // value_a, value_b, value_c, value_d, yaw_total
    output logic [imucfd_pkg::OUT_DATA_W-1:0]       m_tdata,
    // kind
    output logic [1:0]                              m_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [imucfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imucfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NS = imucfd_pkg::N_STAGES;
    localparam int NL = imucfd_pkg::N_LANES;
    localparam int RW = imucfd_pkg::RAW_W;

    imucfd_pkg::cfg_t     cfg;
    imucfd_pkg::lane_en_t lane_en;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] rdy;

    logic [imucfd_pkg::BYTE_W-1:0] byte_in [1:7];
    logic                          in_known;
    logic                          in_wide;
    imucfd_pkg::kind_t             in_kind;
    logic [RW-1:0]                 in_raw [NL];

    imucfd_pkg::kind_t  kind_reg [0:4];
    logic [RW-1:0]      raw_reg [NL];
    logic               wide_reg;
    imucfd_pkg::range_t lane_rng [NL];

    logic signed [imucfd_pkg::VAL_W-1:0] lane_value [NL];
    logic signed [imucfd_pkg::VAL_W-1:0] out_value_reg [NL];
    imucfd_pkg::kind_t                   out_kind_reg;
    logic signed [imucfd_pkg::TOT_OUT_W-1:0] yaw_total;

    imucfd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame decode at the input.
    always_comb
    begin
        for (int i = 1; i <= 7; i++)
        begin
            byte_in[i] = s_tdata[imucfd_pkg::ID_W + 8 * (i - 1) +: 8];
        end
        in_known = 1'b1;
        in_wide  = 1'b1;
        in_kind  = imucfd_pkg::KIND_ACCEL;
        unique case (s_tuser)
            imucfd_pkg::FT_ACCEL: in_kind = imucfd_pkg::KIND_ACCEL;
            imucfd_pkg::FT_GYRO:  in_kind = imucfd_pkg::KIND_GYRO;
            imucfd_pkg::FT_EULER: in_kind = imucfd_pkg::KIND_EULER;
            imucfd_pkg::FT_QUAT:
            begin
                in_kind = imucfd_pkg::KIND_QUAT;
                in_wide = 1'b0;
            end
            default: in_known = 1'b0;
        endcase
        if (in_wide)
        begin
            in_raw[0] = {byte_in[3], byte_in[2]};
            in_raw[1] = {byte_in[5], byte_in[4]};
            in_raw[2] = {byte_in[7], byte_in[6]};
            in_raw[3] = '0;
        end
        else
        begin
            // Four 14-bit values packed most significant bit first.
            in_raw[0] = RW'({byte_in[1], byte_in[2][7:2]});
            in_raw[1] = RW'({byte_in[2][1:0], byte_in[3], byte_in[4][7:4]});
            in_raw[2] = RW'({byte_in[4][3:0], byte_in[5], byte_in[6][7:6]});
            in_raw[3] = RW'({byte_in[6][5:0], byte_in[7]});
        end
    end

    // Each stage may load when it is empty or its item moves on.
    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = s_tvalid && in_known &&
                            (s_tdata[imucfd_pkg::ID_W-1:0] == cfg.match_id);
        end
        for (int i = 1; i < NS; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = valid_reg[i - 1];
            end
        end
    end

    assign s_tready   = rdy[0];
    assign lane_en.s1 = rdy[1];
    assign lane_en.s2 = rdy[2];
    assign lane_en.s3 = rdy[3];
    assign lane_en.s4 = rdy[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            kind_reg[0] <= in_kind;
            raw_reg     <= in_raw;
            wide_reg    <= in_wide;
        end
        for (int i = 1; i <= 4; i++)
        begin
            if (rdy[i])
            begin
                kind_reg[i] <= kind_reg[i - 1];
            end
        end
        if (rdy[NS-1])
        begin
            out_kind_reg  <= kind_reg[4];
            out_value_reg <= lane_value;
        end
    end

    // Range of each lane by kind; the fourth lane maps to zero unless quaternion.
    always_comb
    begin
        unique case (kind_reg[0])
            imucfd_pkg::KIND_ACCEL:
            begin
                lane_rng[0] = cfg.accel;
                lane_rng[1] = cfg.accel;
                lane_rng[2] = cfg.accel;
                lane_rng[3] = '0;
            end
            imucfd_pkg::KIND_GYRO:
            begin
                lane_rng[0] = cfg.gyro;
                lane_rng[1] = cfg.gyro;
                lane_rng[2] = cfg.gyro;
                lane_rng[3] = '0;
            end
            imucfd_pkg::KIND_EULER:
            begin
                lane_rng[0] = cfg.pitch;
                lane_rng[1] = cfg.yaw;
                lane_rng[2] = cfg.roll;
                lane_rng[3] = '0;
            end
            default:
            begin
                lane_rng[0] = cfg.quat;
                lane_rng[1] = cfg.quat;
                lane_rng[2] = cfg.quat;
                lane_rng[3] = cfg.quat;
            end
        endcase
    end

    for (genvar g = 0; g < NL; g++)
    begin : g_lane
        imucfd_lane u_lane
        (
            .clk   (clk),
            .en    (lane_en),
            .raw   (raw_reg[g]),
            .wide  (wide_reg),
            .rng   (lane_rng[g]),
            .value (lane_value[g])
        );
    end

    imucfd_yaw u_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rdy[NS-1] && valid_reg[4]),
        .euler     (kind_reg[4] == imucfd_pkg::KIND_EULER),
        .yaw       (lane_value[1]),
        .yaw_total (yaw_total)
    );

    assign m_tvalid = valid_reg[NS-1];
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {yaw_total, out_value_reg[3], out_value_reg[2],
                       out_value_reg[1], out_value_reg[0]};

    // An empty pipeline never refuses an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> s_tready)
        else $error("input refused with an empty pipeline");

    // A result appears only after an item sat in the last lane stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(valid_reg[4]))
        else $error("result appeared without an item behind it");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != imucfd_pkg::KIND_EULER)) |-> (yaw_total == '0))
        else $error("total yaw set on a frame that is not Euler");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != imucfd_pkg::KIND_QUAT)) |-> (out_value_reg[3] == '0))
        else $error("fourth value set on a frame that is not quaternion");

endmodule

FILE: sv/imucfd_cfg.sv
module imucfd_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imucfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imucfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output imucfd_pkg::cfg_t                     cfg
);

    imucfd_pkg::cfg_t   cfg_reg;
    imucfd_pkg::cfg_t   cfg_next;
    imucfd_pkg::range_t wr_range;
    logic [imucfd_pkg::MAG_W-1:0] span;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // The span is worked out once at the write, away from the item path.
    always_comb
    begin
        span = {cfg_data[63], cfg_data[63:32]} - {cfg_data[31], cfg_data[31:0]};
        wr_range.lo  = cfg_data[31:0];
        wr_range.neg = span[imucfd_pkg::MAG_W-1];
        wr_range.mag = wr_range.neg ? (~span + imucfd_pkg::MAG_W'(1)) : span;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                imucfd_pkg::REG_MATCH_ID: cfg_next.match_id = cfg_data[imucfd_pkg::ID_W-1:0];
                imucfd_pkg::REG_ACCEL:    cfg_next.accel    = wr_range;
                imucfd_pkg::REG_GYRO:     cfg_next.gyro     = wr_range;
                imucfd_pkg::REG_PITCH:    cfg_next.pitch    = wr_range;
                imucfd_pkg::REG_YAW:      cfg_next.yaw      = wr_range;
                imucfd_pkg::REG_ROLL:     cfg_next.roll     = wr_range;
                imucfd_pkg::REG_QUAT:     cfg_next.quat     = wr_range;
                default:                  cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/imucfd_lane.sv
module imucfd_lane
(
    input  logic                                    clk,
    input  imucfd_pkg::lane_en_t                    en,
    input  logic [imucfd_pkg::RAW_W-1:0]            raw,
    input  logic                                    wide,
    input  imucfd_pkg::range_t                      rng,
    output logic signed [imucfd_pkg::VAL_W-1:0]     value
);

    localparam int VW = imucfd_pkg::VAL_W;
    localparam int RW = imucfd_pkg::RAW_W;
    localparam int FW = imucfd_pkg::FOLD_W;

    // Stage 1: magnitude product.
    logic [imucfd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [RW+imucfd_pkg::MAG_W-1:0] prod_full;
    logic signed [VW-1:0] lo1_reg, lo2_reg, lo3_reg;
    logic neg1_reg, neg2_reg, neg3_reg;
    logic wide1_reg, wide2_reg;

    // Stage 2: first fold of the division by 2^k - 1.
    logic [VW-1:0] a_reg, a_next;
    logic [FW-1:0] s_reg, s_next;
    logic [RW-1:0] b;

    // Stage 3: quotient.
    logic [FW-1:0] q_reg, q_next;
    logic [18:0]   a2;
    logic [RW-1:0] b2;
    logic [19:0]   t;
    logic [5:0]    a3;
    logic [RW-1:0] b3;
    logic [RW:0]   u;
    logic [RW-1:0] den;
    logic          corr;

    // Stage 4: mapped value.
    logic signed [VW-1:0] value_reg, value_next;

    assign prod_full = (RW + imucfd_pkg::MAG_W)'(raw) * (RW + imucfd_pkg::MAG_W)'(rng.mag);
    assign prod_next = prod_full[imucfd_pkg::PROD_W-1:0];

    // n = a*2^k + b = a*(2^k - 1) + (a + b), since 2^k is 1 modulo the divisor.
    always_comb
    begin
        if (wide1_reg)
        begin
            a_next = prod_reg[47:16];
            b      = prod_reg[15:0];
        end
        else
        begin
            a_next = prod_reg[45:14];
            b      = {2'b00, prod_reg[13:0]};
        end
        s_next = FW'(a_next) + FW'(b);
    end

    // Two more folds leave a remainder below twice the divisor.
    always_comb
    begin
        if (wide2_reg)
        begin
            a2  = {2'b00, s_reg[32:16]};
            b2  = s_reg[15:0];
            den = imucfd_pkg::DEN_WIDE;
        end
        else
        begin
            a2  = s_reg[32:14];
            b2  = {2'b00, s_reg[13:0]};
            den = imucfd_pkg::DEN_QUAT;
        end
        t = 20'(a2) + 20'(b2);
        if (wide2_reg)
        begin
            a3 = {2'b00, t[19:16]};
            b3 = t[15:0];
        end
        else
        begin
            a3 = t[19:14];
            b3 = {2'b00, t[13:0]};
        end
        u      = (RW + 1)'(a3) + (RW + 1)'(b3);
        corr   = (u >= (RW + 1)'(den));
        q_next = FW'(a_reg) + FW'(a2) + FW'(a3) + FW'(corr);
    end

    // The quotient of the magnitude is the quotient truncated towards zero.
    assign value_next = neg3_reg ? (lo3_reg - q_reg[VW-1:0]) : (lo3_reg + q_reg[VW-1:0]);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg  <= prod_next;
            lo1_reg   <= rng.lo;
            neg1_reg  <= rng.neg;
            wide1_reg <= wide;
        end
        if (en.s2)
        begin
            a_reg     <= a_next;
            s_reg     <= s_next;
            lo2_reg   <= lo1_reg;
            neg2_reg  <= neg1_reg;
            wide2_reg <= wide1_reg;
        end
        if (en.s3)
        begin
            q_reg    <= q_next;
            lo3_reg  <= lo2_reg;
            neg3_reg <= neg2_reg;
        end
        if (en.s4)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: sv/imucfd_yaw.sv
module imucfd_yaw
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  logic                                        euler,
    input  logic signed [imucfd_pkg::VAL_W-1:0]         yaw,
    output logic signed [imucfd_pkg::TOT_OUT_W-1:0]     yaw_total
);

    localparam int DW = imucfd_pkg::DIFF_W;
    localparam int TW = imucfd_pkg::TOT_W;

    logic signed [imucfd_pkg::VAL_W-1:0]     last_yaw_reg;
    logic signed [imucfd_pkg::TURN_W-1:0]    turn_reg, turn_next;
    logic signed [imucfd_pkg::TOT_OUT_W-1:0] total_reg, total_next;
    logic signed [DW-1:0] diff;
    logic signed [TW-1:0] turn_ext;
    logic signed [TW-1:0] turn_const;
    logic signed [TW-1:0] yaw_ext;
    logic signed [TW-1:0] total_full;

    always_comb
    begin
        diff      = DW'(yaw) - DW'(last_yaw_reg);
        turn_next = turn_reg;
        if (diff > imucfd_pkg::HALF_TURN)
        begin
            if (turn_reg != imucfd_pkg::TURN_MIN)
            begin
                turn_next = turn_reg - imucfd_pkg::TURN_W'(1);
            end
        end
        else if (diff < -imucfd_pkg::HALF_TURN)
        begin
            if (turn_reg != imucfd_pkg::TURN_MAX)
            begin
                turn_next = turn_reg + imucfd_pkg::TURN_W'(1);
            end
        end
        turn_ext   = TW'(turn_next);
        turn_const = TW'(imucfd_pkg::FULL_TURN);
        yaw_ext    = TW'(yaw);
        total_full = turn_const * turn_ext + yaw_ext;
        if (!euler)
        begin
            total_next = '0;
        end
        else if (total_full > imucfd_pkg::TOTAL_MAX)
        begin
            total_next = imucfd_pkg::TOTAL_MAX[imucfd_pkg::TOT_OUT_W-1:0];
        end
        else if (total_full < imucfd_pkg::TOTAL_MIN)
        begin
            total_next = imucfd_pkg::TOTAL_MIN[imucfd_pkg::TOT_OUT_W-1:0];
        end
        else
        begin
            total_next = total_full[imucfd_pkg::TOT_OUT_W-1:0];
        end
    end

    // The turn state moves only as an Euler item enters the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_yaw_reg <= '0;
            turn_reg     <= '0;
        end
        else if (load && euler)
        begin
            last_yaw_reg <= yaw;
            turn_reg     <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            total_reg <= total_next;
        end
    end

    assign yaw_total = total_reg;

endmodule
